>>> hw/rtl/vse_pkg.sv
// ----------------------------------------------------------------------------
// vse_pkg: shared types and constants of the visual string escaper
// Character codes and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package vse_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] PRINT_LO       = 8'h20;
  localparam logic [7:0] PRINT_HI       = 8'h7E;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // latch the accepted byte and the emission flags
    logic store;     // append the accepted byte to the pending buffer
    logic set_long;  // a long printable run starts
    logic clr_long;  // the long printable run ends
    logic esc_pend;  // pending bytes are to be escaped
    logic emit_pend; // send one word from the pending buffer
    logic emit_cur;  // send one word from the current byte
  } vse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic printable;  // byte on the input is printable
    logic in_eos;     // byte on the input ends the string
    logic long_run;   // a long printable run is active
    logic run_done;   // pending bytes plus this one reach the run length
    logic count_zero; // pending buffer is empty
    logic out_free;   // output register can take a word this cycle
    logic step_done;  // the word now selected is the last of its byte
    logic pend_last;  // the pending byte now selected is the last one
  } vse_stat_t;

endpackage

>>> hw/rtl/vse_ctrl.sv
// ----------------------------------------------------------------------------
// vse_ctrl: controller of the visual string escaper
// Classifies each accepted byte and sequences the flush of the pending buffer
// and the emission of the current byte.
// ----------------------------------------------------------------------------
module vse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  vse_pkg::vse_stat_t  stat_i,
  output vse_pkg::vse_cmd_t   cmd_o
);
  import vse_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PEND = 2'd1;
  localparam logic [1:0] S_CUR  = 2'd2;

  logic [1:0] state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          if (stat_i.printable) begin
            if (stat_i.long_run) begin
              cmd_o.take = 1'b1;
              state_d    = S_CUR;
            end else if (stat_i.run_done || stat_i.in_eos) begin
              cmd_o.take     = 1'b1;
              cmd_o.set_long = stat_i.run_done;
              state_d        = stat_i.count_zero ? S_CUR : S_PEND;
            end else begin
              cmd_o.store = 1'b1;
            end
          end else begin
            cmd_o.take     = 1'b1;
            cmd_o.clr_long = 1'b1;
            cmd_o.esc_pend = 1'b1;
            if (stat_i.long_run || stat_i.count_zero) begin
              state_d = S_CUR;
            end else begin
              state_d = S_PEND;
            end
          end
          // The end of a string always leaves the run state cleared.
          if (stat_i.in_eos) begin
            cmd_o.clr_long = 1'b1;
          end
        end
      end
      S_PEND: begin
        cmd_o.emit_pend = stat_i.out_free;
        if (stat_i.out_free && stat_i.step_done && stat_i.pend_last) begin
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        cmd_o.emit_cur = stat_i.out_free;
        if (stat_i.out_free && stat_i.step_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/vse_datapath.sv
// ----------------------------------------------------------------------------
// vse_datapath: storage and character generation of the visual string escaper
// Holds the run length register, the pending buffer, the run state, the
// current byte and the output register.
// ----------------------------------------------------------------------------
module vse_datapath #(
  parameter int MAX_RUN = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [3:0]          cfg_data_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eos_i,
  input  vse_pkg::vse_cmd_t   cmd_i,
  output vse_pkg::vse_stat_t  stat_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [7:0]          m_data_o,
  output logic                m_last_o,
  output logic                m_user_o
);
  import vse_pkg::*;

  localparam int DEPTH = MAX_RUN - 1;
  localparam int CW    = $clog2(MAX_RUN);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]    rl_q;
  logic [4:0]    rl_eff;
  logic [7:0]    pend_q [DEPTH];
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx_q;
  logic [1:0]    dig_q;
  logic          long_q;
  logic [7:0]    cur_q;
  logic          eos_q;
  logic          esc_cur_q;
  logic          esc_pend_q;

  logic          m_valid_q;
  logic [7:0]    m_data_q;
  logic          m_last_q;
  logic          m_user_q;

  logic [7:0]    sel_byte;
  logic          sel_esc;
  logic [7:0]    char_w;
  logic          emit;
  logic          step_done;
  logic          pend_last;

  // Run length zero acts as one; values above MAX_RUN saturate.
  always_comb begin
    if (rl_q == 4'd0) begin
      rl_eff = 5'd1;
    end else if ({1'b0, rl_q} > 5'(MAX_RUN)) begin
      rl_eff = 5'(MAX_RUN);
    end else begin
      rl_eff = {1'b0, rl_q};
    end
  end

  assign sel_byte  = cmd_i.emit_cur ? cur_q : pend_q[idx_q];
  assign sel_esc   = cmd_i.emit_cur ? esc_cur_q : esc_pend_q;
  assign step_done = !sel_esc || (dig_q == 2'd3);
  assign pend_last = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign emit      = cmd_i.emit_pend || cmd_i.emit_cur;

  always_comb begin
    if (!sel_esc) begin
      char_w = sel_byte;
    end else begin
      case (dig_q)
        2'd0:    char_w = CHAR_BACKSLASH;
        2'd1:    char_w = CHAR_ZERO + {6'd0, sel_byte[7:6]};
        2'd2:    char_w = CHAR_ZERO + {5'd0, sel_byte[5:3]};
        default: char_w = CHAR_ZERO + {5'd0, sel_byte[2:0]};
      endcase
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.printable  = (in_byte_i >= PRINT_LO) && (in_byte_i <= PRINT_HI);
    stat_o.in_eos     = in_eos_i;
    stat_o.long_run   = long_q;
    stat_o.run_done   = (5'(cnt_q) + 5'd1) >= rl_eff;
    stat_o.count_zero = (cnt_q == '0);
    stat_o.out_free   = !m_valid_q || m_ready_i;
    stat_o.step_done  = step_done;
    stat_o.pend_last  = pend_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q      <= 4'd4;
      cnt_q     <= '0;
      idx_q     <= '0;
      dig_q     <= 2'd0;
      long_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rl_q <= cfg_data_i;
      end
      if (cmd_i.clr_long) begin
        long_q <= 1'b0;
      end else if (cmd_i.set_long) begin
        long_q <= 1'b1;
      end
      if (cmd_i.take) begin
        idx_q <= '0;
        dig_q <= 2'd0;
      end
      if (cmd_i.store) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (emit) begin
        dig_q <= step_done ? 2'd0 : dig_q + 2'd1;
      end
      if (cmd_i.emit_pend && step_done) begin
        idx_q <= idx_q + IW'(1);
        if (pend_last) begin
          cnt_q <= '0;
        end
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_q      <= in_byte_i;
      eos_q      <= in_eos_i;
      esc_cur_q  <= !stat_o.printable;
      esc_pend_q <= cmd_i.esc_pend;
    end
    if (cmd_i.store) begin
      pend_q[cnt_q[IW-1:0]] <= in_byte_i;
    end
    if (emit) begin
      m_data_q <= char_w;
      m_user_q <= cmd_i.emit_cur && step_done;
      m_last_q <= cmd_i.emit_cur && step_done && eos_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;
  assign m_user_o  = m_user_q;

endmodule

>>> hw/rtl/visual_string_escaper.sv
// ----------------------------------------------------------------------------
// visual_string_escaper: visible rendering of a byte stream
// Takes one byte a word and gives printable runs that reach the run length or
// end the string raw, other bytes as backslash and three octal digits.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one byte of the string in tdata and marks the
//   final byte with tlast. The master stream carries one character a word in
//   tdata; tuser flags the last character caused by an input byte and tlast
//   flags the last character of the whole string. The cfg channel writes the
//   run length; it is always ready and should only be written while idle.
//   A printable byte that is only buffered gives no output. Any other byte is
//   accepted and then gives one output character a word: one per raw byte,
//   four per escaped byte, so up to 4*MAX_RUN words for a flush of the
//   pending buffer plus the current byte. The rate is set by the output
//   register, which moves one word a cycle while the receiver is ready; the
//   next byte is accepted as soon as the last word of the previous one sits
//   in that register. A stalled receiver holds the controller in place.
//   Reset clears the run state and the pending count and sets run length 4.
// ----------------------------------------------------------------------------
module visual_string_escaper #(
  parameter int MAX_RUN = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,     // run_length
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // string_done
  output logic       m_axis_tuser    // last_of_item
);
  import vse_pkg::*;

  vse_cmd_t  cmd;
  vse_stat_t stat;

  assign cfg_ready_o = 1'b1;

  vse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  vse_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .m_user_o    (m_axis_tuser)
  );

endmodule

>>> hw/rtl/vse_checker.sv
// ----------------------------------------------------------------------------
// vse_checker: port-level assertions for the visual string escaper
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module vse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);
  import vse_pkg::*;

  // A stalled output word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // The end of the string is always the last character of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("string end without item end");

  // A non-printable byte always produces output, so the input closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    ((s_axis_tdata < PRINT_LO) || (s_axis_tdata > PRINT_HI)) |=> !s_axis_tready)
    else $error("non-printable byte accepted without emission");

  // The final byte of a string always produces output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("string end accepted without emission");

endmodule

bind visual_string_escaper vse_checker u_vse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> sim/visual_string_escaper_checker.sv
// ----------------------------------------------------------------------------
// visual_string_escaper_checker: scoreboard for the visual string escaper
// Watches the configuration channel and both streams. Keeps its own copy of
// the run state, works out the characters that each accepted byte should give
// and compares every accepted output word, field by field, in order.
// ----------------------------------------------------------------------------
module visual_string_escaper_checker #(
  parameter int MAX_RUN = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [3:0] cfg_data_i,     // run_length
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // end_of_string
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // out_char
  input  logic       m_axis_tlast,   // string_done
  input  logic       m_axis_tuser,   // last_of_item
  output int         words_due_o,
  output int         mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import vse_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       item_end;
    logic       str_end;
  } char_word_t;

  char_word_t chars_due_q[$];
  logic [7:0] held_bytes[MAX_RUN-1];
  int         held_count;
  bit         long_run;
  logic [3:0] run_length;
  int         mismatches;
  int         words_due;
  char_word_t got;

  assign words_due_o  = words_due;
  assign mismatches_o = mismatches;

  function automatic void push_char(input logic [7:0] c);
    chars_due_q.push_back('{ch: c, item_end: 1'b0, str_end: 1'b0});
  endfunction

  function automatic void push_escape(input logic [7:0] b);
    push_char(CHAR_BACKSLASH);
    push_char(CHAR_ZERO + {6'd0, b[7:6]});
    push_char(CHAR_ZERO + {5'd0, b[5:3]});
    push_char(CHAR_ZERO + {5'd0, b[2:0]});
  endfunction

  function automatic void flush_held(input bit escaped);
    for (int i = 0; i < held_count; i++) begin
      if (escaped) begin
        push_escape(held_bytes[i]);
      end else begin
        push_char(held_bytes[i]);
      end
    end
    held_count = 0;
  endfunction

  // Works out the characters caused by one accepted byte.
  task automatic escape_byte(input logic [7:0] b, input logic eos);
    int         first;
    int         limit;
    char_word_t last_w;
    first = chars_due_q.size();
    // A run length of zero acts as one; anything above the buffer saturates.
    limit = (run_length == 4'd0) ? 1 : int'(run_length);
    if (limit > MAX_RUN) limit = MAX_RUN;
    if (b >= PRINT_LO && b <= PRINT_HI) begin
      if (long_run) begin
        push_char(b);
      end else if (held_count + 1 >= limit || eos || held_count >= MAX_RUN - 1) begin
        if (held_count + 1 >= limit) long_run = 1'b1;
        flush_held(1'b0);
        push_char(b);
      end else begin
        held_bytes[held_count] = b;
        held_count++;
      end
    end else begin
      if (long_run) begin
        long_run = 1'b0;
      end else begin
        flush_held(1'b1);
      end
      push_escape(b);
    end
    if (chars_due_q.size() > first) begin
      last_w = chars_due_q.pop_back();
      last_w.item_end = 1'b1;
      last_w.str_end  = eos;
      chars_due_q.push_back(last_w);
    end
    if (eos) begin
      held_count = 0;
      long_run   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_due_q.delete();
      held_count = 0;
      long_run   = 1'b0;
      run_length = 4'd4;
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (chars_due_q.size() == 0) begin
          $error("unexpected word: out_char %h, last_of_item %b, string_done %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          got = chars_due_q.pop_front();
          if (got.ch !== m_axis_tdata) begin
            $error("out_char: expected %h, got %h", got.ch, m_axis_tdata);
            mismatches++;
          end
          if (got.item_end !== m_axis_tuser) begin
            $error("last_of_item: expected %b, got %b", got.item_end, m_axis_tuser);
            mismatches++;
          end
          if (got.str_end !== m_axis_tlast) begin
            $error("string_done: expected %b, got %b", got.str_end, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) run_length = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) escape_byte(s_axis_tdata, s_axis_tlast);
    end
    words_due = chars_due_q.size();
  end

endmodule

>>> sim/visual_string_escaper_tb.sv
// ----------------------------------------------------------------------------
// visual_string_escaper_tb: testbench top of the visual string escaper
// Drives whole strings into the block under several run lengths, with random
// gaps on both streams, a long receiver hold-off and a sender pause. A
// checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module visual_string_escaper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vse_pkg::*;

  localparam int MAX_RUN      = 8;
  localparam int CLK_HALF     = 1;
  localparam int DRAIN_CYCLES = 4 * MAX_RUN + 8;
  localparam int HOLD_CYCLES  = 250;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  int words_due;
  int mismatches;
  bit hold_off_req = 1'b0;
  bit steady_phase = 1'b0;

  visual_string_escaper #(
    .MAX_RUN(MAX_RUN)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  visual_string_escaper_checker #(
    .MAX_RUN(MAX_RUN)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .words_due_o  (words_due),
    .mismatches_o (mismatches)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = steady_phase ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Lowers valid and waits until every expected word has been received.
  task automatic wait_for_quiet(input bit settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    if (settle) repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_run_length(input logic [3:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one whole string: mostly printable runs of varied length split by
  // non-printable bytes, sometimes plain noise. The last byte carries tlast.
  task automatic send_string(output int count);
    logic [7:0] text_q[$];
    int         r;
    int         run;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        if (r < 10) run = 0;
        else if (r < 55) run = $urandom_range(1, 4);
        else if (r < 85) run = $urandom_range(5, 9);
        else run = $urandom_range(10, 14);
        repeat (run) text_q.push_back(8'($urandom_range(int'(PRINT_LO), int'(PRINT_HI))));
        if ($urandom_range(0, 9) < 7) begin
          text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(127, 255)));
        end
      end
      if (text_q.size() == 0) text_q.push_back(8'h7F);
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    count = text_q.size();
  endtask

  // Receiver: random stalls, occasional long hold-off on request.
  initial begin : receiver
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else if (steady_phase) begin
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int         sent;
    int         count;
    bit         paused;
    logic [3:0] setting;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 4'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    paused        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset run length of four.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b0);             // held back
    send_byte(8'h7F, 1'b0);             // short run escaped with it
    send_byte(PRINT_LO, 1'b0);
    send_byte(PRINT_HI, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);    // completes the run, all four go raw
    send_byte(PRINT_HI, 1'b0);          // long run continues raw
    send_byte(8'h1F, 1'b0);             // ends the long run
    send_byte(PRINT_LO, 1'b1);          // short final run still goes raw
    send_byte(8'h80, 1'b1);
    send_byte(8'h78, 1'b0);
    send_byte(8'h79, 1'b0);
    send_byte(8'h0A, 1'b1);             // pending pair escaped at end of string
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_quiet(1'b1);
      case (phase)
        1:       setting = 4'd0;
        2:       setting = 4'd1;
        3:       setting = 4'd15;
        4:       setting = 4'd8;
        5:       setting = 4'd2;
        default: setting = 4'($urandom_range(1, 8));
      endcase
      if (phase > 0) write_run_length(setting);
      steady_phase = (phase == 4);
      if (phase == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if (phase == 3 && sent >= PHASE_BYTES / 2 && !paused) begin
          wait_for_quiet(1'b0);
          paused = 1'b1;
        end
        send_string(count);
        sent += count;
      end
    end

    wait_for_quiet(1'b1);
    if (mismatches == 0) begin
      $display("visual_string_escaper_tb: done, clean");
    end else begin
      $display("visual_string_escaper_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("visual_string_escaper_tb: done, errors");
    $finish;
  end

endmodule
